// ===== rtl/core/euler_xyz_point_rotator_top_macros.svh =====
// ----------------------------------------------------------------------------
// euler xyz point rotator assertion macros
// concurrent assertion wrappers clocked on clk, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef EULER_XYZ_POINT_ROTATOR_TOP_MACROS_SVH
`define EULER_XYZ_POINT_ROTATOR_TOP_MACROS_SVH

// checked only outside reset
`define EXYZR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define EXYZR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/exyzr_pkg.sv =====
// ----------------------------------------------------------------------------
// exyzr_pkg
// shared widths, cordic constants and parameter defaults of the point rotator
// ----------------------------------------------------------------------------
`default_nettype none

package exyzr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;

  // trig values are q2.30, angles are turn units with 2^32 a full turn
  localparam int TRIG_W    = 32;
  localparam int TRIG_FRAC = 30;
  localparam int TURN_W    = 32;

  // low slice of the multiplicand in the split multiply
  localparam int LO_W = 16;

  localparam logic signed [TRIG_W-1:0] GAIN_Q30         = 32'sd652032874;
  localparam logic signed [TURN_W-1:0] TURN_QUARTER     = 32'sh4000_0000;
  localparam logic signed [TURN_W-1:0] TURN_NEG_QUARTER = 32'shC000_0000;

  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [TURN_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
    32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
    32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
    32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
    32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
  };

endpackage

`default_nettype wire

// ===== rtl/core/euler_xyz_point_rotator_top.sv =====
// throughput: one point per cycle; each register stage has its own valid bit
// and stalls only when it holds a beat that the next stage cannot take
// the cordic pipeline sets the depth: one micro-rotation per stage
// reset clears the valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
// euler_xyz_point_rotator_top
// rotates a q16.16 point about x, then y, then z, with saturation on output
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_point_rotator_top #(
  parameter int CORDIC_STAGES = exyzr_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = exyzr_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = exyzr_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] coord_x_in,
  input  logic signed [COORD_WIDTH-1:0] coord_y_in,
  input  logic signed [COORD_WIDTH-1:0] coord_z_in,
  input  logic signed [ANGLE_WIDTH-1:0] angle_x,
  input  logic signed [ANGLE_WIDTH-1:0] angle_y,
  input  logic signed [ANGLE_WIDTH-1:0] angle_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] coord_x_out,
  output logic signed [COORD_WIDTH-1:0] coord_y_out,
  output logic signed [COORD_WIDTH-1:0] coord_z_out,
  output logic                          saturated
);

  localparam int NCS = (CORDIC_STAGES < exyzr_pkg::ATAN_ENTRIES) ?
                       CORDIC_STAGES : exyzr_pkg::ATAN_ENTRIES;
  localparam int IW  = COORD_WIDTH + 2;
  localparam int TW  = exyzr_pkg::TRIG_W;
  localparam int ZW  = exyzr_pkg::TURN_W;

  // stage map
  localparam int S_XA  = NCS + 1;
  localparam int S_XB  = NCS + 2;
  localparam int S_YA  = NCS + 3;
  localparam int S_YB  = NCS + 4;
  localparam int S_ZA  = NCS + 5;
  localparam int S_ZB  = NCS + 6;
  localparam int S_OUT = NCS + 7;
  localparam int NST   = NCS + 8;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------- flow
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  assign adv[NST-1] = !vld[NST-1] || out_ready;
  for (genvar i = 0; i < NST-1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (adv & {vld[NST-2:0], in_valid}) | (~adv & vld);
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NST-1];

  // ---------------------------------------------------------------- angle fold
  logic signed [ZW-1:0] turn_in [3];
  logic signed [ZW-1:0] ang0    [3];
  logic                 flip0   [3];

  assign turn_in[0] = {angle_x, {(ZW-ANGLE_WIDTH){1'b0}}};
  assign turn_in[1] = {angle_y, {(ZW-ANGLE_WIDTH){1'b0}}};
  assign turn_in[2] = {angle_z, {(ZW-ANGLE_WIDTH){1'b0}}};

  logic signed [TW-1:0] trig_c [3];
  logic signed [TW-1:0] trig_s [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic fold;
    // a half turn away is the msb flipped, with sine and cosine negated
    assign fold = (turn_in[a] > exyzr_pkg::TURN_QUARTER) ||
                  (turn_in[a] < exyzr_pkg::TURN_NEG_QUARTER);

    always_ff @(posedge clk) begin
      if (adv[0]) begin
        ang0[a]  <= fold ? {~turn_in[a][ZW-1], turn_in[a][ZW-2:0]} : turn_in[a];
        flip0[a] <= fold;
      end
    end

    exyzr_cordic #(
      .NCS (NCS)
    ) u_cordic (
      .clk     (clk),
      .adv     (adv[NCS:1]),
      .z_in    (ang0[a]),
      .flip_in (flip0[a]),
      .cos_out (trig_c[a]),
      .sin_out (trig_s[a])
    );
  end

  // ---------------------------------------------------------------- delay lines
  logic signed [COORD_WIDTH-1:0] xd [S_XB+1];
  logic signed [COORD_WIDTH-1:0] yd [NCS+1];
  logic signed [COORD_WIDTH-1:0] zd [NCS+1];

  for (genvar i = 0; i <= S_XB; i++) begin : g_xd
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv[0]) xd[0] <= coord_x_in;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (adv[i]) xd[i] <= xd[i-1];
      end
    end
  end

  for (genvar i = 0; i <= NCS; i++) begin : g_yzd
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv[0]) begin
          yd[0] <= coord_y_in;
          zd[0] <= coord_z_in;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (adv[i]) begin
          yd[i] <= yd[i-1];
          zd[i] <= zd[i-1];
        end
      end
    end
  end

  // y-axis trig waits out the x rotation, z-axis trig the x and y rotations
  logic signed [TW-1:0] cyd [2];
  logic signed [TW-1:0] syd [2];
  logic signed [TW-1:0] czd [4];
  logic signed [TW-1:0] szd [4];

  for (genvar i = 0; i < 4; i++) begin : g_trigd
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (adv[S_XA]) begin
          cyd[0] <= trig_c[1];
          syd[0] <= trig_s[1];
          czd[0] <= trig_c[2];
          szd[0] <= trig_s[2];
        end
      end
    end else begin : g_tail
      if (i < 2) begin : g_y
        always_ff @(posedge clk) begin
          if (adv[S_XA+i]) begin
            cyd[i] <= cyd[i-1];
            syd[i] <= syd[i-1];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv[S_XA+i]) begin
          czd[i] <= czd[i-1];
          szd[i] <= szd[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- rotations
  logic signed [IW-1:0] py, pz1, pz2, px, ox, oy;
  logic signed [IW-1:0] pyd [2];
  logic signed [IW-1:0] pzd [2];

  exyzr_rot #(
    .IW (IW)
  ) u_rot_x (
    .clk (clk),
    .adv (adv[S_XB:S_XA]),
    .a   (IW'(yd[NCS])),
    .b   (IW'(zd[NCS])),
    .c   (trig_c[0]),
    .s   (trig_s[0]),
    .r0  (py),
    .r1  (pz1)
  );

  // (pz, x) turned by the y angle gives (pz', px)
  exyzr_rot #(
    .IW (IW)
  ) u_rot_y (
    .clk (clk),
    .adv (adv[S_YB:S_YA]),
    .a   (pz1),
    .b   (IW'(xd[S_XB])),
    .c   (cyd[1]),
    .s   (syd[1]),
    .r0  (pz2),
    .r1  (px)
  );

  exyzr_rot #(
    .IW (IW)
  ) u_rot_z (
    .clk (clk),
    .adv (adv[S_ZB:S_ZA]),
    .a   (px),
    .b   (pyd[1]),
    .c   (czd[3]),
    .s   (szd[3]),
    .r0  (ox),
    .r1  (oy)
  );

  always_ff @(posedge clk) begin
    if (adv[S_YA]) pyd[0] <= py;
    if (adv[S_YB]) pyd[1] <= pyd[0];
    if (adv[S_ZA]) pzd[0] <= pz2;
    if (adv[S_ZB]) pzd[1] <= pzd[0];
  end

  // ---------------------------------------------------------------- clip
  // msb is the clip flag
  function automatic logic [COORD_WIDTH:0] clip(input logic signed [IW-1:0] v);
    logic ovf;
    ovf = (v[IW-1:COORD_WIDTH-1] != {(IW-COORD_WIDTH+1){v[IW-1]}});
    if (!ovf) return {1'b0, v[COORD_WIDTH-1:0]};
    else if (v[IW-1]) return {1'b1, CMIN};
    else return {1'b1, CMAX};
  endfunction

  logic [COORD_WIDTH:0] cx, cy, cz;

  assign cx = clip(ox);
  assign cy = clip(oy);
  assign cz = clip(pzd[1]);

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      coord_x_out <= cx[COORD_WIDTH-1:0];
      coord_y_out <= cy[COORD_WIDTH-1:0];
      coord_z_out <= cz[COORD_WIDTH-1:0];
      saturated   <= cx[COORD_WIDTH] | cy[COORD_WIDTH] | cz[COORD_WIDTH];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/exyzr_cordic.sv =====
// ----------------------------------------------------------------------------
// exyzr_cordic
// pipelined rotation-mode cordic, one micro-rotation per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module exyzr_cordic #(
  parameter int NCS = exyzr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                    clk,
  input  logic [NCS-1:0]                          adv,
  input  logic signed [exyzr_pkg::TURN_W-1:0]     z_in,
  input  logic                                    flip_in,
  output logic signed [exyzr_pkg::TRIG_W-1:0]     cos_out,
  output logic signed [exyzr_pkg::TRIG_W-1:0]     sin_out
);

  localparam int TW = exyzr_pkg::TRIG_W;
  localparam int ZW = exyzr_pkg::TURN_W;

  logic signed [TW-1:0] xr [NCS];
  logic signed [TW-1:0] yr [NCS];
  logic signed [ZW-1:0] zr [NCS-1];
  logic                 fr [NCS-1];

  for (genvar k = 0; k < NCS; k++) begin : g_stage
    logic signed [TW-1:0] x0, y0, xs, ys, xn, yn;
    logic signed [ZW-1:0] z0;
    logic                 f0;

    if (k == 0) begin : g_first
      assign x0 = exyzr_pkg::GAIN_Q30;
      assign y0 = '0;
      assign z0 = z_in;
      assign f0 = flip_in;
    end else begin : g_next
      assign x0 = xr[k-1];
      assign y0 = yr[k-1];
      assign z0 = zr[k-1];
      assign f0 = fr[k-1];
    end

    assign xs = x0 >>> k;
    assign ys = y0 >>> k;
    // residual angle negative: rotate clockwise
    assign xn = z0[ZW-1] ? x0 + ys : x0 - ys;
    assign yn = z0[ZW-1] ? y0 - xs : y0 + xs;

    if (k < NCS-1) begin : g_mid
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          xr[k] <= xn;
          yr[k] <= yn;
          zr[k] <= z0[ZW-1] ? z0 + exyzr_pkg::ATAN_TURNS[k] : z0 - exyzr_pkg::ATAN_TURNS[k];
          fr[k] <= f0;
        end
      end
    end else begin : g_last
      // undo the half-turn fold
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          xr[k] <= f0 ? -xn : xn;
          yr[k] <= f0 ? -yn : yn;
        end
      end
    end
  end

  assign cos_out = xr[NCS-1];
  assign sin_out = yr[NCS-1];

endmodule

`default_nettype wire

// ===== rtl/core/exyzr_rot.sv =====
// ----------------------------------------------------------------------------
// exyzr_rot
// two-stage planar rotation: split products, then round and sum
// ----------------------------------------------------------------------------
`default_nettype none

module exyzr_rot #(
  parameter int IW = exyzr_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic                                clk,
  input  logic [1:0]                          adv,
  input  logic signed [IW-1:0]                a,
  input  logic signed [IW-1:0]                b,
  input  logic signed [exyzr_pkg::TRIG_W-1:0] c,
  input  logic signed [exyzr_pkg::TRIG_W-1:0] s,
  output logic signed [IW-1:0]                r0,
  output logic signed [IW-1:0]                r1
);

  localparam int TW   = exyzr_pkg::TRIG_W;
  localparam int LW   = exyzr_pkg::LO_W;
  localparam int FRAC = exyzr_pkg::TRIG_FRAC;
  localparam int PLW  = LW + 1 + TW;
  localparam int PHW  = IW - LW + TW;
  localparam int FW   = IW + TW + 1;
  localparam logic signed [FW-1:0] RND = FW'(64'sd1 << (FRAC - 1));

  // round half up of (ph * 2^LW + pl) / 2^FRAC
  function automatic logic signed [IW:0] round_q30(input logic signed [PHW-1:0] ph,
                                                   input logic signed [PLW-1:0] pl);
    logic signed [FW-1:0] full;
    full = (FW'(ph) <<< LW) + FW'(pl) + RND;
    return full[FRAC +: IW+1];
  endfunction

  logic signed [LW:0]      a_lo, b_lo;
  logic signed [IW-LW-1:0] a_hi, b_hi;

  assign a_lo = $signed({1'b0, a[LW-1:0]});
  assign b_lo = $signed({1'b0, b[LW-1:0]});
  assign a_hi = a[IW-1:LW];
  assign b_hi = b[IW-1:LW];

  logic signed [PLW-1:0] ac_lo, as_lo, bc_lo, bs_lo;
  logic signed [PHW-1:0] ac_hi, as_hi, bc_hi, bs_hi;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ac_lo <= a_lo * c;
      as_lo <= a_lo * s;
      bc_lo <= b_lo * c;
      bs_lo <= b_lo * s;
      ac_hi <= a_hi * c;
      as_hi <= a_hi * s;
      bc_hi <= b_hi * c;
      bs_hi <= b_hi * s;
    end
  end

  logic signed [IW:0] r0_next, r1_next;

  assign r0_next = round_q30(ac_hi, ac_lo) - round_q30(bs_hi, bs_lo);
  assign r1_next = round_q30(as_hi, as_lo) + round_q30(bc_hi, bc_lo);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      r0 <= r0_next[IW-1:0];
      r1 <= r1_next[IW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/exyzr_checker.sv =====
// ----------------------------------------------------------------------------
// exyzr_checker
// port-level checks on the point rotator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_xyz_point_rotator_top_macros.svh"

module exyzr_checker #(
  parameter int COORD_WIDTH = exyzr_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] coord_x_out,
  input logic signed [COORD_WIDTH-1:0] coord_y_out,
  input logic signed [COORD_WIDTH-1:0] coord_z_out,
  input logic                          saturated
);

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                   out_stall;
  logic                   at_limit;
  logic [3*COORD_WIDTH:0] out_beat;

  assign out_stall = out_valid && !out_ready;
  assign at_limit  = (coord_x_out == CMAX) || (coord_x_out == CMIN) ||
                     (coord_y_out == CMAX) || (coord_y_out == CMIN) ||
                     (coord_z_out == CMAX) || (coord_z_out == CMIN);
  assign out_beat  = {coord_x_out, coord_y_out, coord_z_out, saturated};

  // pipeline empties on reset
  `EXYZR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output beat right after reset")

  // a free output side never holds back the input
  `EXYZR_ASSERT(a_no_block, (out_ready || !out_valid) |-> in_ready, "input stalled")

  // a clipped result carries a coordinate at the range limit
  `EXYZR_ASSERT(a_sat_limit, (out_valid && saturated) |-> at_limit, "flag without limit")

  `EXYZR_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_beat), "held beat changed")

endmodule

bind euler_xyz_point_rotator_top exyzr_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_exyzr_checker (.*);

`default_nettype wire
